// ===== hdl/vnrm_pkg.sv =====
// ----------------------------------------------------------------------------
// vnrm_pkg
// shared constants, queue entry type and root unit state type
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vnrm_pkg;

  localparam int SampleBits = 24;
  localparam int MaxElems   = 65536;
  localparam int CountW     = 17;
  localparam int SqW        = 2 * SampleBits;
  localparam int SumW       = 63;
  localparam int NormW      = 32;
  localparam int ValW       = 2 * NormW;
  localparam int RemW       = NormW + 2;
  localparam int SqrtSteps  = NormW;
  localparam int StepW      = $clog2(SqrtSteps);

  // finished vector handed from the accumulator to the root unit
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic            ovf;
  } vnrm_entry_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_CALC,
    SQ_FLUSH
  } sq_state_e;

endpackage

// ===== hdl/vnrm_front.sv =====
// ----------------------------------------------------------------------------
// vnrm_front
// takes samples, squares them and keeps the running sum, count and overflow
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vnrm_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_valid_i,
  output logic                            s_ready_o,
  input  logic [vnrm_pkg::SampleBits-1:0] sample_i,
  input  logic                            last_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output vnrm_pkg::vnrm_entry_t           q_entry_o
);

  logic                            a_valid_q;
  logic                            a_last_q;
  logic                            a_add_q;
  logic                            a_ovf_q;
  logic [vnrm_pkg::SqW-1:0]        a_sq_q;
  logic [vnrm_pkg::CountW-1:0]     count_q;
  logic                            ovf_q;
  logic [vnrm_pkg::SumW-1:0]       sum_q;

  logic                            a_consume;
  logic                            accept;
  logic                            drop;
  logic [vnrm_pkg::SampleBits-1:0] mag;
  logic [vnrm_pkg::SumW-1:0]       sum_next;

  assign a_consume = a_valid_q && (!a_last_q || !q_full_i);
  assign s_ready_o = !a_valid_q || a_consume;
  assign accept    = s_valid_i && s_ready_o;
  assign drop      = (count_q == vnrm_pkg::CountW'(vnrm_pkg::MaxElems));
  assign mag       = sample_i[vnrm_pkg::SampleBits-1] ? (~sample_i + 1'b1) : sample_i;

  assign sum_next  = sum_q + (a_add_q ? {{(vnrm_pkg::SumW-vnrm_pkg::SqW){1'b0}}, a_sq_q}
                                      : '0);

  assign q_push_o      = a_consume && a_last_q;
  assign q_entry_o.sum = sum_next;
  assign q_entry_o.ovf = a_ovf_q;

  // square stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_last_q  <= 1'b0;
      a_add_q   <= 1'b0;
      a_ovf_q   <= 1'b0;
      count_q   <= '0;
      ovf_q     <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
      a_last_q  <= last_i;
      a_add_q   <= !drop;
      a_ovf_q   <= ovf_q | drop;
      if (last_i) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        if (!drop) begin
          count_q <= count_q + 1'b1;
        end
        ovf_q <= ovf_q | drop;
      end
    end else if (a_consume) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_sq_q <= vnrm_pkg::SqW'(mag) * vnrm_pkg::SqW'(mag);
    end
  end

  // running sum, cleared once a finished vector goes into the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (a_consume) begin
      sum_q <= a_last_q ? '0 : sum_next;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= vnrm_pkg::CountW'(vnrm_pkg::MaxElems))
    else $error("element count beyond limit");

  a_push_only_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> !q_full_i)
    else $error("push into full queue");

endmodule

// ===== hdl/vnrm_queue.sv =====
// ----------------------------------------------------------------------------
// vnrm_queue
// two-entry queue of finished sums between accumulator and root unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vnrm_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  vnrm_pkg::vnrm_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output vnrm_pkg::vnrm_entry_t entry_o
);

  vnrm_pkg::vnrm_entry_t entries_q [2];
  logic                  wr_ptr_q;
  logic                  rd_ptr_q;
  logic [1:0]            cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign entry_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue overrun");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("queue underrun");

endmodule

// ===== hdl/vnrm_sqrt.sv =====
// ----------------------------------------------------------------------------
// vnrm_sqrt
// bit-pair restoring square root, one result bit per cycle, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vnrm_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  vnrm_pkg::vnrm_entry_t      q_entry_i,
  output logic                       q_pop_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [vnrm_pkg::NormW-1:0] norm_o,
  output logic                       ovf_o
);

  vnrm_pkg::sq_state_e state_q, state_d;

  logic [vnrm_pkg::ValW-1:0]  val_q;
  logic [vnrm_pkg::RemW-1:0]  rem_q;
  logic [vnrm_pkg::NormW-1:0] root_q;
  logic [vnrm_pkg::StepW-1:0] step_q;
  logic                       ovf_q;
  logic                       out_valid_q;
  logic [vnrm_pkg::NormW-1:0] out_norm_q;
  logic                       out_ovf_q;

  logic                       out_free;
  logic                       load;
  logic                       step;
  logic                       write_out;
  logic [vnrm_pkg::RemW+1:0]  rem_sh;
  logic [vnrm_pkg::RemW+1:0]  trial;
  logic [vnrm_pkg::RemW+1:0]  rem_sub;
  logic                       ge;

  assign out_free = !out_valid_q || m_ready_i;

  // next remainder and root bit
  assign rem_sh  = {rem_q, val_q[vnrm_pkg::ValW-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vnrm_pkg::SQ_IDLE: begin
        if (q_valid_i) begin
          state_d = vnrm_pkg::SQ_CALC;
        end
      end
      vnrm_pkg::SQ_CALC: begin
        if (step_q == '0) begin
          state_d = vnrm_pkg::SQ_FLUSH;
        end
      end
      vnrm_pkg::SQ_FLUSH: begin
        if (out_free) begin
          state_d = vnrm_pkg::SQ_IDLE;
        end
      end
      default: state_d = vnrm_pkg::SQ_IDLE;
    endcase
  end

  always_comb begin
    load      = 1'b0;
    step      = 1'b0;
    write_out = 1'b0;
    unique case (state_q)
      vnrm_pkg::SQ_IDLE:  load      = q_valid_i;
      vnrm_pkg::SQ_CALC:  step      = 1'b1;
      vnrm_pkg::SQ_FLUSH: write_out = out_free;
      default: ;
    endcase
  end

  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vnrm_pkg::SQ_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (write_out) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      val_q  <= {{(vnrm_pkg::ValW-vnrm_pkg::SumW){1'b0}}, q_entry_i.sum};
      rem_q  <= '0;
      root_q <= '0;
      step_q <= vnrm_pkg::StepW'(vnrm_pkg::SqrtSteps - 1);
      ovf_q  <= q_entry_i.ovf;
    end else if (step) begin
      val_q  <= {val_q[vnrm_pkg::ValW-3:0], 2'b00};
      rem_q  <= ge ? rem_sub[vnrm_pkg::RemW-1:0] : rem_sh[vnrm_pkg::RemW-1:0];
      root_q <= {root_q[vnrm_pkg::NormW-2:0], ge};
      step_q <= step_q - 1'b1;
    end
    if (write_out) begin
      out_norm_q <= root_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign norm_o    = out_norm_q;
  assign ovf_o     = out_ovf_q;

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vnrm_pkg::SQ_FLUSH && out_valid_q && !m_ready_i)
      |=> state_q == vnrm_pkg::SQ_FLUSH)
    else $error("result dropped while output stalled");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == vnrm_pkg::SQ_CALC)
    else $error("pop outside idle");

endmodule

// ===== hdl/vector_euclidean_norm_core.sv =====
// ----------------------------------------------------------------------------
// vector_euclidean_norm_core
// streaming l2 norm of signed q8.16 vectors
// ----------------------------------------------------------------------------
// samples enter on the s_axis channel, one word per element, tlast on the
// final element of a vector. each sample is squared exactly and added into a
// 63-bit sum; elements past 65536 in one vector are dropped and flagged.
// one result word per vector leaves on m_axis: floor(sqrt(sum)) in q16.16 on
// tdata and the overflow flag on tuser.
// the accumulator takes one sample per cycle unless stalled. a finished sum
// goes through a two-entry queue to the root unit, which produces one root
// bit per cycle: it loads a sum, iterates once per result bit, writes the
// output register and only then takes the next sum. a last sample passes the
// square stage, queue, root unit and output register before m_axis_tvalid
// rises; vectors that come faster back up into the queue and then stall
// s_axis_tready. when m_axis_tready is low the result holds in the output
// register, the root unit waits with its next result and the accumulator
// keeps taking samples until a last sample meets a full queue. reset clears
// the sum, count, flag, queue and output valid; ready as soon as reset ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_euclidean_norm_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // sample[23:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // norm_value[31:0]
  output logic        m_axis_tuser    // overflowed
);

  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_valid;
  vnrm_pkg::vnrm_entry_t q_in;
  vnrm_pkg::vnrm_entry_t q_out;

  vnrm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sample_i  (s_axis_tdata[vnrm_pkg::SampleBits-1:0]),
    .last_i    (s_axis_tlast),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_in)
  );

  vnrm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  vnrm_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_out),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .norm_o    (m_axis_tdata),
    .ovf_o     (m_axis_tuser)
  );

endmodule
